// ===== rtl/fhm_pkg.sv =====
// Shared types and constants for the FIFO handoff mutex.
// Used by fhm_queue and fifo_handoff_mutex; depends on nothing.
package fhm_pkg;

  localparam int MAX_WAITERS = 16;
  localparam int TASK_W      = 4;
  localparam int IDX_W       = $clog2(MAX_WAITERS);
  localparam int CNT_W       = $clog2(MAX_WAITERS + 1);

  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_FREED     = 3'd2;
  localparam logic [2:0] ST_HANDOFF   = 3'd3;
  localparam logic [2:0] ST_NOT_OWNER = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic KIND_LOCK   = 1'b0;
  localparam logic KIND_UNLOCK = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [TASK_W-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              woken_valid;
    logic [TASK_W-1:0] woken_task;
    logic              held_after;
    logic [TASK_W-1:0] owner_after;
  } rsp_t;

  // Commands from the mutex control to the wait queue.
  typedef struct packed {
    logic rd;    // capture the entry at the head
    logic push;
    logic pop;
  } q_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ===== rtl/fhm_queue.sv =====
// Wait queue of the FIFO handoff mutex: ring of task ids in a synchronous
// memory with head, tail and fill count. Depends on fhm_pkg.
module fhm_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  fhm_pkg::q_cmd_t            cmd,
  input  logic [fhm_pkg::TASK_W-1:0] push_id,
  output logic [fhm_pkg::TASK_W-1:0] head_id,
  output fhm_pkg::q_stat_t           stat
);
  import fhm_pkg::*;

  logic [TASK_W-1:0] mem [MAX_WAITERS];
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  count;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    wrap_inc = (i == IDX_W'(MAX_WAITERS - 1)) ? '0 : i + 1'b1;
  endfunction

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(MAX_WAITERS));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= push_id;
    end
    if (cmd.rd) begin
      head_id <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push) begin
        tail <= wrap_inc(tail);
      end
      if (cmd.pop) begin
        head <= wrap_inc(head);
      end
      if (cmd.push && !cmd.pop) begin
        count <= count + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/fifo_handoff_mutex.sv =====
// FIFO handoff mutex: lock and unlock requests, with waiters queued in order.
// The request is captured while the queue head is read from memory, then it is
// resolved and its result registered; no new request is taken until that result
// is registered, and so none is taken while a result stalls.
// Reset: synchronous, frees the mutex and empties the queue; queue memory is
// not cleared (only written entries are ever used).
module fifo_handoff_mutex (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  fhm_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output fhm_pkg::rsp_t out_data
);
  import fhm_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state;
  logic              state_next;
  logic              req_kind;
  logic [TASK_W-1:0] req_task;
  logic              lock_held;
  logic              lock_held_next;
  logic [TASK_W-1:0] owner_id;
  logic [TASK_W-1:0] owner_id_next;
  logic [TASK_W-1:0] head_id;
  q_cmd_t            q_cmd;
  q_stat_t           q_stat;
  rsp_t              rsp;
  logic              in_xfer;
  logic              out_free;
  logic              done;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign done     = (state == S_EXEC) && out_free;

  fhm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .cmd     (q_cmd),
    .push_id (req_task),
    .head_id (head_id),
    .stat    (q_stat)
  );

  // Resolve the held request against the owner and the captured queue head.
  always_comb begin
    lock_held_next  = lock_held;
    owner_id_next   = owner_id;
    rsp             = '0;
    q_cmd           = '0;
    q_cmd.rd        = in_xfer;
    if (req_kind == KIND_LOCK) begin
      if (!lock_held) begin
        lock_held_next = 1'b1;
        owner_id_next  = req_task;
        rsp.status     = ST_GRANTED;
      end else if (!q_stat.full) begin
        q_cmd.push = done;
        rsp.status = ST_QUEUED;
      end else begin
        rsp.status = ST_FULL;
      end
    end else begin
      if (!lock_held || owner_id != req_task) begin
        rsp.status = ST_NOT_OWNER;
      end else if (!q_stat.empty) begin
        q_cmd.pop       = done;
        owner_id_next   = head_id;
        rsp.woken_valid = 1'b1;
        rsp.woken_task  = head_id;
        rsp.status      = ST_HANDOFF;
      end else begin
        lock_held_next = 1'b0;
        owner_id_next  = '0;
        rsp.status     = ST_FREED;
      end
    end
    rsp.held_after  = lock_held_next;
    rsp.owner_after = lock_held_next ? owner_id_next : '0;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lock_held <= 1'b0;
      owner_id  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done) begin
        lock_held <= lock_held_next;
        owner_id  <= owner_id_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_kind <= in_data.kind;
      req_task <= in_data.task_id;
    end
    if (done) begin
      out_data <= rsp;
    end
  end

  a_owner_zero_when_free: assert property (@(posedge clk) disable iff (rst)
    !lock_held |-> owner_id == '0)
    else $error("owner not cleared while mutex is free");

  a_no_push_and_pop: assert property (@(posedge clk) disable iff (rst)
    !(q_cmd.push && q_cmd.pop))
    else $error("queue pushed and popped by one request");

  a_queue_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |-> lock_held)
    else $error("waiters queued on a free mutex");

  a_handoff_keeps_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_HANDOFF |->
      out_data.woken_valid && out_data.held_after
      && out_data.owner_after == out_data.woken_task)
    else $error("handoff result inconsistent");

endmodule
